FILE: rtl/ormon_pkg.sv
// ----------------------------------------------------------------------------
// ormon_pkg
// Shared constants, register indexes and controller/datapath bundles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ormon_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_UPDATES   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_RATE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALING_ENABLE = 3'd4;

    // field widths
    localparam int TS_W    = 64;
    localparam int RATE_W  = 32;
    localparam int WIN_W   = 5;
    localparam int THR_W   = 21;
    localparam int SKIP_W  = 16;
    localparam int INRATE_W = 20;
    localparam int IVAL_W  = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd16;

    // rate numerator: 1000000 * window, window below 32
    localparam int                  SCALE_W    = 20;
    localparam logic [SCALE_W-1:0]  RATE_SCALE = 20'd1000000;
    localparam int                  NUM_W      = SCALE_W + WIN_W;
    localparam int                  DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(NUM_W - 1);

    // signed width for input_rate - output_rate against the threshold
    localparam int CMP_W = RATE_W + 2;

    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic sum_run;    // walk the interval ring
        logic div_load;   // capture window sum, set up the divider
        logic div_run;    // one quotient bit
        logic finish;     // load the result register
    } ormon_cmd_t;

    typedef struct packed {
        logic started;    // a previous timestamp is held
        logic skip;       // this beat only repeats the last rate
        logic sum_done;   // last ring entry is being added
        logic div_done;   // last quotient bit is being formed
    } ormon_status_t;

endpackage

FILE: rtl/ormon_if.sv
// ----------------------------------------------------------------------------
// ormon_if
// Valid/ready channels for timestamps in and rate results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ormon_ts_if;
    logic        valid;
    logic        ready;
    logic [63:0] timestamp_us;

    modport source (output valid, output timestamp_us, input ready);
    modport sink   (input valid, input timestamp_us, output ready);
endinterface

interface ormon_rate_if;
    logic        valid;
    logic        ready;
    logic [31:0] output_rate;
    logic        compared;
    logic        raise_frequency;

    modport source (output valid, output output_rate, output compared,
                    output raise_frequency, input ready);
    modport sink   (input valid, input output_rate, input compared,
                    input raise_frequency, output ready);
endinterface

FILE: rtl/output_rate_monitor_core.sv
// ----------------------------------------------------------------------------
// output_rate_monitor_core
// Measures message output rate over a ring of intervals, flags slow output
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   -------   ---   ----------------   ----------------------------------------
//   in_ch     in    valid / ready      timestamp_us[63:0]
//   out_ch    out   valid / ready      output_rate[31:0], compared,
//                                      raise_frequency
//   cfg       in    cfg_we (no ready)  cfg_index[2:0], cfg_wdata[20:0]
//
// sequence: the first beat after reset gives no result; a skipped update
//   goes straight from the beat to the result register; a full update walks
//   the interval ring one read per cycle and then runs the 25-step serial
//   divider before its result is loaded
// reset: rst_n clears all control and block state at once, no clearing pass;
//   never-written ring entries read as zero through per-entry valid bits
// stalls: a finished result waits in the output register; the next beat is
//   taken as soon as the sequencer is idle, and a later result waits in the
//   sequencer until the output register frees up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module output_rate_monitor_core
    import ormon_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ormon_ts_if.sink               in_ch,
    ormon_rate_if.source           out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // command and status bundles between sequencer and datapath
    ormon_cmd_t    cmd;
    ormon_status_t status;

    // sequencer owns both handshakes
    ormon_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath holds config, ring, divider and the result register
    ormon_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .timestamp_us    (in_ch.timestamp_us),
        .cmd             (cmd),
        .status          (status),
        .output_rate     (out_ch.output_rate),
        .compared        (out_ch.compared),
        .raise_frequency (out_ch.raise_frequency)
    );

    // a result beat only appears right after the result register was loaded
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.finish))
        else $error("result beat without a finish command");

    // no new beat is taken while an update is in flight
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !(cmd.sum_run || cmd.div_load || cmd.div_run))
        else $error("input ready during an update");

    // a frequency request only comes with a recomputed rate
    a_raise_needs_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.raise_frequency) |-> out_ch.compared)
        else $error("raise request on a skipped update");

    // ring walk and divider never finish together
    a_phase_split: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.sum_done && status.div_done))
        else $error("sum and divide overlap");

endmodule

FILE: rtl/ormon_ram.sv
// ----------------------------------------------------------------------------
// ormon_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ormon_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ormon_ctrl.sv
// ----------------------------------------------------------------------------
// ormon_ctrl
// Sequencer: accept, ring sum, serial divide, result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ormon_ctrl
    import ormon_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  ormon_status_t status,
    output ormon_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    if (!status.started)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.skip)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (status.sum_done)
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_run = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/ormon_dp.sv
// ----------------------------------------------------------------------------
// ormon_dp
// Datapath: config registers, interval ring, window sum, divider, compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ormon_dp
    import ormon_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [TS_W-1:0]        timestamp_us,
    input  ormon_cmd_t             cmd,
    output ormon_status_t          status,
    output logic [RATE_W-1:0]      output_rate,
    output logic                   compared,
    output logic                   raise_frequency
);

    localparam int IDX_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WMAX_EFF = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
    localparam int SUM_W    = IVAL_W + $clog2(WMAX_EFF + 1);
    localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WMAX_EFF);

    function automatic logic [IDX_W-1:0] to_addr(input logic [WIN_W-1:0] idx);
        logic [IDX_W+WIN_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, idx};
        return wide[IDX_W-1:0];
    endfunction

    // configuration
    logic [WIN_W-1:0]    window_size_reg;
    logic [THR_W-1:0]    rate_threshold_reg;
    logic [SKIP_W-1:0]   skip_updates_reg;
    logic [INRATE_W-1:0] input_rate_reg;
    logic                scaling_enable_reg;

    // block state
    logic [TS_W-1:0]       prev_time_reg;
    logic                  started_reg;
    logic [WIN_W-1:0]      write_slot_reg;
    logic [SKIP_W-1:0]     skip_cnt_reg;
    logic [RATE_W-1:0]     last_rate_reg;
    logic [WINDOW_MAX-1:0] valid_reg;
    logic                  skip_mode_reg;

    // ring walk
    logic [WIN_W-1:0] rd_idx_reg;
    logic             issue_reg;
    logic             data_valid_reg;
    logic             last_reg;
    logic             vbit_reg;
    logic [SUM_W-1:0] acc_reg;

    // divider
    logic [SUM_W-1:0]     divisor_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 zero_reg;

    // result register
    logic [RATE_W-1:0] out_rate_reg;
    logic              out_cmp_reg;
    logic              out_raise_reg;

    logic [WIN_W-1:0]  win;
    logic [TS_W-1:0]   diff;
    logic [IVAL_W-1:0] interval;
    logic [WIN_W-1:0]  slot;
    logic [WIN_W-1:0]  slot_inc;
    logic [WIN_W-1:0]  slot_next;
    logic [SKIP_W-1:0] skip_inc;
    logic              ring_we;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic [IVAL_W-1:0] rdata;
    logic              rd_last;
    logic [SUM_W:0]    rem_sh;
    logic              rem_ge;
    logic [RATE_W-1:0] rate;
    logic signed [CMP_W-1:0] excess;
    logic signed [CMP_W-1:0] thr_ext;
    logic              raise;

    // window in use: zero counts as one, capped at the ring depth and at 31
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win = WIN_W'(1);
        end
        else if (window_size_reg > WIN_CAP)
        begin
            win = WIN_CAP;
        end
        else
        begin
            win = window_size_reg;
        end
    end

    assign diff      = timestamp_us - prev_time_reg;
    assign interval  = (|diff[TS_W-1:IVAL_W]) ? '1 : diff[IVAL_W-1:0];
    assign slot      = (write_slot_reg >= win) ? '0 : write_slot_reg;
    assign slot_inc  = slot + WIN_W'(1);
    assign slot_next = (slot_inc == win) ? '0 : slot_inc;
    assign skip_inc  = (skip_cnt_reg == '1) ? skip_cnt_reg : skip_cnt_reg + SKIP_W'(1);

    assign ring_we = cmd.accept && started_reg;
    assign waddr   = to_addr(slot);
    assign raddr   = to_addr(rd_idx_reg);
    assign rd_last = (rd_idx_reg == win - WIN_W'(1));

    ormon_ram #(
        .WIDTH (IVAL_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (waddr),
        .wdata (interval),
        .raddr (raddr),
        .rdata (rdata)
    );

    // restoring divide step
    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, divisor_reg});

    assign rate    = zero_reg ? '1 : RATE_W'(quo_reg);
    assign excess  = $signed({{(CMP_W-INRATE_W){1'b0}}, input_rate_reg})
                   - $signed({2'b00, rate});
    assign thr_ext = $signed({{(CMP_W-THR_W){rate_threshold_reg[THR_W-1]}},
                              rate_threshold_reg});
    assign raise   = scaling_enable_reg && (excess > thr_ext);

    always_comb
    begin
        status.started  = started_reg;
        status.skip     = (skip_inc < skip_updates_reg);
        status.sum_done = data_valid_reg && last_reg;
        status.div_done = cmd.div_run && (div_cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg    <= WINDOW_RESET;
            rate_threshold_reg <= '0;
            skip_updates_reg   <= '0;
            input_rate_reg     <= '0;
            scaling_enable_reg <= 1'b0;
            prev_time_reg      <= '0;
            started_reg        <= 1'b0;
            write_slot_reg     <= '0;
            skip_cnt_reg       <= '0;
            last_rate_reg      <= '0;
            valid_reg          <= '0;
            skip_mode_reg      <= 1'b0;
            issue_reg          <= 1'b0;
            data_valid_reg     <= 1'b0;
            last_reg           <= 1'b0;
            rd_idx_reg         <= '0;
            div_cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_SIZE:    window_size_reg    <= cfg_wdata[WIN_W-1:0];
                    CFG_RATE_THRESHOLD: rate_threshold_reg <= cfg_wdata[THR_W-1:0];
                    CFG_SKIP_UPDATES:   skip_updates_reg   <= cfg_wdata[SKIP_W-1:0];
                    CFG_INPUT_RATE:     input_rate_reg     <= cfg_wdata[INRATE_W-1:0];
                    CFG_SCALING_ENABLE: scaling_enable_reg <= cfg_wdata[0];
                    default:            ;
                endcase
            end

            if (cmd.accept)
            begin
                prev_time_reg <= timestamp_us;
                started_reg   <= 1'b1;
                rd_idx_reg    <= '0;
                issue_reg     <= 1'b1;
                if (started_reg)
                begin
                    valid_reg[waddr] <= 1'b1;
                    write_slot_reg   <= slot_next;
                    skip_cnt_reg     <= skip_inc;
                    skip_mode_reg    <= status.skip;
                end
            end

            // one ring read issued per cycle, data lands in the cycle after
            data_valid_reg <= 1'b0;
            if (cmd.sum_run && issue_reg)
            begin
                data_valid_reg <= 1'b1;
                last_reg       <= rd_last;
                rd_idx_reg     <= rd_idx_reg + WIN_W'(1);
                issue_reg      <= !rd_last;
            end

            if (cmd.div_load)
            begin
                div_cnt_reg <= DIV_LAST_STEP;
            end
            else if (cmd.div_run)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end

            if (cmd.finish && !skip_mode_reg)
            begin
                last_rate_reg <= rate;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vbit_reg <= valid_reg[raddr];

        if (cmd.accept)
        begin
            acc_reg <= '0;
        end
        else if (data_valid_reg && vbit_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(rdata);
        end

        if (cmd.div_load)
        begin
            divisor_reg <= acc_reg;
            zero_reg    <= (acc_reg == '0);
            rem_reg     <= '0;
            quo_reg     <= {{WIN_W{1'b0}}, RATE_SCALE} * {{SCALE_W{1'b0}}, win};
        end
        else if (cmd.div_run)
        begin
            rem_reg <= rem_ge ? SUM_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[SUM_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
        end

        if (cmd.finish)
        begin
            if (skip_mode_reg)
            begin
                out_rate_reg  <= last_rate_reg;
                out_cmp_reg   <= 1'b0;
                out_raise_reg <= 1'b0;
            end
            else
            begin
                out_rate_reg  <= rate;
                out_cmp_reg   <= 1'b1;
                out_raise_reg <= raise;
            end
        end
    end

    assign output_rate     = out_rate_reg;
    assign compared        = out_cmp_reg;
    assign raise_frequency = out_raise_reg;

endmodule
